// ===== src/sme_pkg.sv =====
// ----------------------------------------------------------------------------
// sme_pkg
// Types and constants shared by the spring mass Euler step block.
// ----------------------------------------------------------------------------
`default_nettype none

package sme_pkg;

    localparam int unsigned REG_IDX_W = 3;
    localparam int unsigned CFG_W     = 32;
    localparam int unsigned PROD_W    = 68;
    localparam int unsigned MUL_W     = 34;
    localparam int unsigned DT_BITS   = 16;

    localparam logic [1:0] CMD_STEP  = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_RESET = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [REG_IDX_W-1:0] REG_REST    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_STIFF   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MASS    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DRAG    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GRAV    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_START_X = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_START_Y = 3'd6;

    localparam logic [30:0]        RST_REST    = 31'd655360;
    localparam logic [30:0]        RST_STIFF   = 31'd524288000;
    localparam logic [30:0]        RST_MASS    = 31'd6553600;
    localparam logic [30:0]        RST_DRAG    = 31'd655360;
    localparam logic [30:0]        RST_GRAV    = 31'd655360;
    localparam logic signed [31:0] RST_START_X = 32'sd786432;
    localparam logic signed [31:0] RST_START_Y = 32'sd983040;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] anchor_x;
        logic signed [31:0] anchor_y;
        logic [15:0]        time_step;
    } item_in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [4:0]         anchor_count;
        logic               table_full;
    } item_out_t;

    typedef enum logic [28:0] {
        ST_IDLE   = 29'h00000001,
        ST_FIN    = 29'h00000002,
        ST_ANC_RD = 29'h00000004,
        ST_DIFF   = 29'h00000008,
        ST_SQX    = 29'h00000010,
        ST_SQY    = 29'h00000020,
        ST_SQSUM  = 29'h00000040,
        ST_SQRT   = 29'h00000080,
        ST_DIST   = 29'h00000100,
        ST_KMUL   = 29'h00000200,
        ST_FORCE  = 29'h00000400,
        ST_FXMUL  = 29'h00000800,
        ST_FXLD   = 29'h00001000,
        ST_FYMUL  = 29'h00002000,
        ST_FYLD   = 29'h00004000,
        ST_DIV    = 29'h00008000,
        ST_DIVEND = 29'h00010000,
        ST_GMUL   = 29'h00020000,
        ST_CXMUL  = 29'h00040000,
        ST_CYMUL  = 29'h00080000,
        ST_FSUM   = 29'h00100000,
        ST_FSAT   = 29'h00200000,
        ST_AXLD   = 29'h00400000,
        ST_AYLD   = 29'h00800000,
        ST_VXMUL  = 29'h01000000,
        ST_VYMUL  = 29'h02000000,
        ST_PXMUL  = 29'h04000000,
        ST_PYMUL  = 29'h08000000,
        ST_PUPD   = 29'h10000000
    } state_t;

    typedef enum logic [1:0] {
        DEST_FX = 2'd0,
        DEST_FY = 2'd1,
        DEST_AX = 2'd2,
        DEST_AY = 2'd3
    } div_dest_t;

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -68'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/spring_mass_euler_step.sv =====
// ----------------------------------------------------------------------------
// spring_mass_euler_step
// 2D point mass on a table of spring anchors, semi-implicit Euler in fixed point.
// ----------------------------------------------------------------------------
// Each step walks the stored anchors: each anchor uses one pass of the
// integer square root and, unless it lies at zero distance, two passes of
// the shift-subtract divider, and the closing acceleration takes two more
// divider passes. All products go through one registered 34 x 34 signed
// multiplier. One item is in work at a time; the result register lets the
// next item enter while a result is still waiting.
`default_nettype none

module spring_mass_euler_step #(
    parameter int unsigned MAX_ANCHORS   = 16,
    parameter int unsigned FRACTION_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cmd_valid,
    output      logic                            cmd_stall,
    input  wire sme_pkg::item_in_t               cmd,
    output      logic                            res_valid,
    input  wire logic                            res_stall,
    output      sme_pkg::item_out_t              res,
    input  wire logic                            write_enable,
    input  wire logic [sme_pkg::REG_IDX_W-1:0]   reg_index,
    input  wire logic [sme_pkg::CFG_W-1:0]       write_data
);

    localparam int unsigned CNT_W = $clog2(MAX_ANCHORS + 1);
    localparam int unsigned IDX_W = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;
    localparam int unsigned PW    = sme_pkg::PROD_W;
    localparam int unsigned MW    = sme_pkg::MUL_W;

    sme_pkg::state_t    state_reg, state_next;
    sme_pkg::div_dest_t dest_reg, dest_next;

    logic [30:0]        rest_reg, stiff_reg, mass_reg, drag_reg, grav_reg;
    logic signed [31:0] startx_reg, starty_reg;

    logic signed [31:0] px_reg, px_next, py_reg, py_next;
    logic signed [31:0] vx_reg, vx_next, vy_reg, vy_next;
    logic [CNT_W-1:0]   count_reg, count_next, idx_reg, idx_next;
    logic               full_reg, full_next;
    logic [15:0]        dt_reg, dt_next;
    logic signed [63:0] fx_reg, fx_next, fy_reg, fy_next;
    logic signed [32:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [30:0]        sx_reg, sx_next, sy_reg, sy_next;
    logic               big_reg, big_next;
    logic [63:0]        sq_sum_reg, sq_sum_next, sq_n_reg, sq_n_next;
    logic [63:0]        sq_r_reg, sq_r_next, sq_bit_reg, sq_bit_next;
    logic [32:0]        dist_reg, dist_next;
    logic signed [31:0] stretch_reg, stretch_next, f_reg, f_next;
    logic signed [31:0] fsx_reg, fsx_next, fsy_reg, fsy_next;
    logic signed [31:0] ax_reg, ax_next, ay_reg, ay_next;
    logic [63:0]        dvd_reg, dvd_next;
    logic [32:0]        rem_reg, rem_next, den_reg, den_next;
    logic               neg_reg, neg_next;
    logic [5:0]         dcnt_reg, dcnt_next;
    logic signed [PW-1:0] prod_reg;
    logic [63:0]        rd_data_reg;
    logic               res_valid_reg, res_valid_next;
    sme_pkg::item_out_t res_reg, res_next;

    logic [63:0]        anchor_mem [MAX_ANCHORS];

    logic signed [MW-1:0] mul_a, mul_b;
    logic                 cmd_accept, mem_we, out_free;
    logic signed [PW-1:0] prod_mag, prod_fb, prod_dt;
    logic signed [32:0]   adx, ady;
    logic [32:0]          mx, my;
    logic [63:0]          sq_try;
    logic [33:0]          rem_sh;
    logic signed [63:0]   q_term;
    logic [32:0]          dist_val;
    logic [31:0]          fs_mag;
    logic [30:0]          mass_eff;

    assign cmd_stall  = (state_reg != sme_pkg::ST_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;
    assign out_free   = !res_valid_reg || !res_stall;
    assign mem_we     = cmd_accept && (cmd.command == sme_pkg::CMD_ADD)
                        && (count_reg < CNT_W'(MAX_ANCHORS));

    assign prod_mag = (prod_reg < 0) ? -prod_reg : prod_reg;
    assign prod_fb  = prod_reg >>> FRACTION_BITS;
    assign prod_dt  = prod_reg >>> sme_pkg::DT_BITS;
    assign adx      = {rd_data_reg[63], rd_data_reg[63:32]} - {px_reg[31], px_reg};
    assign ady      = {rd_data_reg[31], rd_data_reg[31:0]} - {py_reg[31], py_reg};
    assign mx       = (adx < 0) ? 33'(-adx) : 33'(adx);
    assign my       = (ady < 0) ? 33'(-ady) : 33'(ady);
    assign sq_try   = sq_r_reg + sq_bit_reg;
    assign rem_sh   = {rem_reg, dvd_reg[63]};
    assign q_term   = neg_reg ? -$signed(dvd_reg) : $signed(dvd_reg);
    assign dist_val = big_reg ? {sq_r_reg[31:0], 1'b0} : {1'b0, sq_r_reg[31:0]};
    assign mass_eff = (mass_reg == 31'd0) ? 31'd1 : mass_reg;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            sme_pkg::ST_SQX:   begin mul_a = MW'(sx_reg);      mul_b = MW'(sx_reg);      end
            sme_pkg::ST_SQY:   begin mul_a = MW'(sy_reg);      mul_b = MW'(sy_reg);      end
            sme_pkg::ST_KMUL:  begin mul_a = MW'(stiff_reg);   mul_b = MW'(stretch_reg); end
            sme_pkg::ST_FXMUL: begin mul_a = MW'(f_reg);       mul_b = MW'(dx_reg);      end
            sme_pkg::ST_FYMUL: begin mul_a = MW'(f_reg);       mul_b = MW'(dy_reg);      end
            sme_pkg::ST_GMUL:  begin mul_a = MW'(mass_reg);    mul_b = MW'(grav_reg);    end
            sme_pkg::ST_CXMUL: begin mul_a = MW'(drag_reg);    mul_b = MW'(vx_reg);      end
            sme_pkg::ST_CYMUL: begin mul_a = MW'(drag_reg);    mul_b = MW'(vy_reg);      end
            sme_pkg::ST_VXMUL: begin mul_a = MW'(ax_reg);      mul_b = MW'(dt_reg);      end
            sme_pkg::ST_VYMUL: begin mul_a = MW'(ay_reg);      mul_b = MW'(dt_reg);      end
            sme_pkg::ST_PXMUL: begin mul_a = MW'(vx_reg);      mul_b = MW'(dt_reg);      end
            sme_pkg::ST_PYMUL: begin mul_a = MW'(vy_reg);      mul_b = MW'(dt_reg);      end
            default:           begin mul_a = '0;               mul_b = '0;               end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        dest_next      = dest_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        full_next      = full_reg;
        dt_next        = dt_reg;
        fx_next        = fx_reg;
        fy_next        = fy_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        big_next       = big_reg;
        sq_sum_next    = sq_sum_reg;
        sq_n_next      = sq_n_reg;
        sq_r_next      = sq_r_reg;
        sq_bit_next    = sq_bit_reg;
        dist_next      = dist_reg;
        stretch_next   = stretch_reg;
        f_next         = f_reg;
        fsx_next       = fsx_reg;
        fsy_next       = fsy_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        neg_next       = neg_reg;
        dcnt_next      = dcnt_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;
        fs_mag         = '0;

        unique case (state_reg)
            sme_pkg::ST_IDLE:
            begin
                if (cmd_accept)
                begin
                    full_next  = 1'b0;
                    state_next = sme_pkg::ST_FIN;
                    case (cmd.command)
                        sme_pkg::CMD_STEP:
                        begin
                            dt_next    = cmd.time_step;
                            idx_next   = '0;
                            fx_next    = '0;
                            fy_next    = '0;
                            state_next = sme_pkg::ST_ANC_RD;
                        end
                        sme_pkg::CMD_ADD:
                        begin
                            if (mem_we)
                                count_next = count_reg + CNT_W'(1);
                            else
                                full_next = 1'b1;
                        end
                        sme_pkg::CMD_RESET:
                        begin
                            px_next    = startx_reg;
                            py_next    = starty_reg;
                            vx_next    = '0;
                            vy_next    = '0;
                            count_next = '0;
                        end
                        default:
                        begin
                            full_next = 1'b0;
                        end
                    endcase
                end
            end
            sme_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    res_valid_next       = 1'b1;
                    res_next.pos_x       = px_reg;
                    res_next.pos_y       = py_reg;
                    res_next.vel_x       = vx_reg;
                    res_next.vel_y       = vy_reg;
                    res_next.anchor_count = 5'(count_reg);
                    res_next.table_full  = full_reg;
                    state_next           = sme_pkg::ST_IDLE;
                end
            end
            sme_pkg::ST_ANC_RD:
            begin
                if (idx_reg < count_reg)
                    state_next = sme_pkg::ST_DIFF;
                else
                    state_next = sme_pkg::ST_GMUL;
            end
            sme_pkg::ST_DIFF:
            begin
                dx_next  = adx;
                dy_next  = ady;
                // halve both magnitudes when either reaches 2^31
                big_next = mx[32] | mx[31] | my[32] | my[31];
                sx_next  = big_next ? mx[31:1] : mx[30:0];
                sy_next  = big_next ? my[31:1] : my[30:0];
                state_next = sme_pkg::ST_SQX;
            end
            sme_pkg::ST_SQX:
            begin
                state_next = sme_pkg::ST_SQY;
            end
            sme_pkg::ST_SQY:
            begin
                sq_sum_next = prod_reg[63:0];
                state_next  = sme_pkg::ST_SQSUM;
            end
            sme_pkg::ST_SQSUM:
            begin
                sq_n_next   = sq_sum_reg + prod_reg[63:0];
                sq_r_next   = '0;
                sq_bit_next = 64'h4000_0000_0000_0000;
                state_next  = sme_pkg::ST_SQRT;
            end
            sme_pkg::ST_SQRT:
            begin
                if (sq_n_reg >= sq_try)
                begin
                    sq_n_next = sq_n_reg - sq_try;
                    sq_r_next = (sq_r_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_r_next = sq_r_reg >> 1;
                end
                sq_bit_next = sq_bit_reg >> 2;
                if (sq_bit_reg[0])
                    state_next = sme_pkg::ST_DIST;
            end
            sme_pkg::ST_DIST:
            begin
                dist_next    = dist_val;
                stretch_next = sme_pkg::sat32(PW'(dist_val) - PW'(rest_reg));
                if (dist_val == '0)
                begin
                    // zero distance: this spring gives no force
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = sme_pkg::ST_ANC_RD;
                end
                else
                begin
                    state_next = sme_pkg::ST_KMUL;
                end
            end
            sme_pkg::ST_KMUL:
            begin
                state_next = sme_pkg::ST_FORCE;
            end
            sme_pkg::ST_FORCE:
            begin
                f_next     = sme_pkg::sat32(prod_fb);
                state_next = sme_pkg::ST_FXMUL;
            end
            sme_pkg::ST_FXMUL:
            begin
                state_next = sme_pkg::ST_FXLD;
            end
            sme_pkg::ST_FXLD, sme_pkg::ST_FYLD:
            begin
                dvd_next   = prod_mag[63:0];
                neg_next   = (prod_reg < 0);
                den_next   = dist_reg;
                rem_next   = '0;
                dcnt_next  = '0;
                dest_next  = (state_reg == sme_pkg::ST_FXLD) ? sme_pkg::DEST_FX
                                                             : sme_pkg::DEST_FY;
                state_next = sme_pkg::ST_DIV;
            end
            sme_pkg::ST_FYMUL:
            begin
                state_next = sme_pkg::ST_FYLD;
            end
            sme_pkg::ST_DIV:
            begin
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_next = 33'(rem_sh - {1'b0, den_reg});
                    dvd_next = {dvd_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[32:0];
                    dvd_next = {dvd_reg[62:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 6'd1;
                if (dcnt_reg == 6'd63)
                    state_next = sme_pkg::ST_DIVEND;
            end
            sme_pkg::ST_DIVEND:
            begin
                unique case (dest_reg)
                    sme_pkg::DEST_FX:
                    begin
                        fx_next    = fx_reg + q_term;
                        state_next = sme_pkg::ST_FYMUL;
                    end
                    sme_pkg::DEST_FY:
                    begin
                        fy_next    = fy_reg + q_term;
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = sme_pkg::ST_ANC_RD;
                    end
                    sme_pkg::DEST_AX:
                    begin
                        ax_next    = sme_pkg::sat32(PW'(q_term));
                        state_next = sme_pkg::ST_AYLD;
                    end
                    sme_pkg::DEST_AY:
                    begin
                        ay_next    = sme_pkg::sat32(PW'(q_term));
                        state_next = sme_pkg::ST_VXMUL;
                    end
                    default:
                    begin
                        state_next = sme_pkg::ST_VXMUL;
                    end
                endcase
            end
            sme_pkg::ST_GMUL:
            begin
                state_next = sme_pkg::ST_CXMUL;
            end
            sme_pkg::ST_CXMUL:
            begin
                fy_next    = fy_reg - 64'(prod_fb);
                state_next = sme_pkg::ST_CYMUL;
            end
            sme_pkg::ST_CYMUL:
            begin
                fx_next    = fx_reg - 64'(prod_fb);
                state_next = sme_pkg::ST_FSUM;
            end
            sme_pkg::ST_FSUM:
            begin
                fy_next    = fy_reg - 64'(prod_fb);
                state_next = sme_pkg::ST_FSAT;
            end
            sme_pkg::ST_FSAT:
            begin
                fsx_next   = sme_pkg::sat32(PW'(fx_reg));
                fsy_next   = sme_pkg::sat32(PW'(fy_reg));
                state_next = sme_pkg::ST_AXLD;
            end
            sme_pkg::ST_AXLD, sme_pkg::ST_AYLD:
            begin
                if (state_reg == sme_pkg::ST_AXLD)
                begin
                    fs_mag    = (fsx_reg < 0) ? 32'(-33'(fsx_reg)) : 32'(fsx_reg);
                    neg_next  = (fsx_reg < 0);
                    dest_next = sme_pkg::DEST_AX;
                end
                else
                begin
                    fs_mag    = (fsy_reg < 0) ? 32'(-33'(fsy_reg)) : 32'(fsy_reg);
                    neg_next  = (fsy_reg < 0);
                    dest_next = sme_pkg::DEST_AY;
                end
                dvd_next   = 64'(fs_mag) << FRACTION_BITS;
                den_next   = 33'(mass_eff);
                rem_next   = '0;
                dcnt_next  = '0;
                state_next = sme_pkg::ST_DIV;
            end
            sme_pkg::ST_VXMUL:
            begin
                state_next = sme_pkg::ST_VYMUL;
            end
            sme_pkg::ST_VYMUL:
            begin
                vx_next    = sme_pkg::sat32(PW'(vx_reg) + prod_dt);
                state_next = sme_pkg::ST_PXMUL;
            end
            sme_pkg::ST_PXMUL:
            begin
                vy_next    = sme_pkg::sat32(PW'(vy_reg) + prod_dt);
                state_next = sme_pkg::ST_PYMUL;
            end
            sme_pkg::ST_PYMUL:
            begin
                px_next    = sme_pkg::sat32(PW'(px_reg) + prod_dt);
                state_next = sme_pkg::ST_PUPD;
            end
            sme_pkg::ST_PUPD:
            begin
                py_next    = sme_pkg::sat32(PW'(py_reg) + prod_dt);
                state_next = sme_pkg::ST_FIN;
            end
            default:
            begin
                state_next = sme_pkg::ST_IDLE;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_reg   <= sme_pkg::RST_REST;
            stiff_reg  <= sme_pkg::RST_STIFF;
            mass_reg   <= sme_pkg::RST_MASS;
            drag_reg   <= sme_pkg::RST_DRAG;
            grav_reg   <= sme_pkg::RST_GRAV;
            startx_reg <= sme_pkg::RST_START_X;
            starty_reg <= sme_pkg::RST_START_Y;
        end
        else if (write_enable)
        begin
            unique case (reg_index)
                sme_pkg::REG_REST:    rest_reg   <= write_data[30:0];
                sme_pkg::REG_STIFF:   stiff_reg  <= write_data[30:0];
                sme_pkg::REG_MASS:    mass_reg   <= write_data[30:0];
                sme_pkg::REG_DRAG:    drag_reg   <= write_data[30:0];
                sme_pkg::REG_GRAV:    grav_reg   <= write_data[30:0];
                sme_pkg::REG_START_X: startx_reg <= write_data;
                sme_pkg::REG_START_Y: starty_reg <= write_data;
                default:              rest_reg   <= rest_reg;
            endcase
        end
    end

    // anchor table, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            anchor_mem[count_reg[IDX_W-1:0]] <= {cmd.anchor_x, cmd.anchor_y};
        rd_data_reg <= anchor_mem[idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sme_pkg::ST_IDLE;
            res_valid_reg <= 1'b0;
            px_reg        <= sme_pkg::RST_START_X;
            py_reg        <= sme_pkg::RST_START_Y;
            vx_reg        <= '0;
            vy_reg        <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            full_reg      <= 1'b0;
            dcnt_reg      <= '0;
            dest_reg      <= sme_pkg::DEST_FX;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            px_reg        <= px_next;
            py_reg        <= py_next;
            vx_reg        <= vx_next;
            vy_reg        <= vy_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            full_reg      <= full_next;
            dcnt_reg      <= dcnt_next;
            dest_reg      <= dest_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg    <= PW'(mul_a) * PW'(mul_b);
        dt_reg      <= dt_next;
        fx_reg      <= fx_next;
        fy_reg      <= fy_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        sx_reg      <= sx_next;
        sy_reg      <= sy_next;
        big_reg     <= big_next;
        sq_sum_reg  <= sq_sum_next;
        sq_n_reg    <= sq_n_next;
        sq_r_reg    <= sq_r_next;
        sq_bit_reg  <= sq_bit_next;
        dist_reg    <= dist_next;
        stretch_reg <= stretch_next;
        f_reg       <= f_next;
        fsx_reg     <= fsx_next;
        fsy_reg     <= fsy_next;
        ax_reg      <= ax_next;
        ay_reg      <= ay_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        den_reg     <= den_next;
        neg_reg     <= neg_next;
        res_reg     <= res_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ANCHORS))
        else $error("anchor count beyond table size");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sme_pkg::ST_FIN && full_reg |-> count_reg == CNT_W'(MAX_ANCHORS))
        else $error("refused add reported with room in table");

    a_step_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_accept && cmd.command == sme_pkg::CMD_STEP |=> state_reg == sme_pkg::ST_ANC_RD)
        else $error("step item did not start anchor walk");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == sme_pkg::ST_FIN))
        else $error("result raised outside finish state");
`endif

endmodule

`default_nettype wire
